>>> design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion shorthands clocked on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every clock edge out of reset
`define ASSERT_HOLDS(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> design/ancb_pkg.sv
// ----------------------------------------------------------------------------
// ancb_pkg
// Shared types, constants and helpers of the alpha-normalized cross blur.
// ----------------------------------------------------------------------------
package ancb_pkg;

	localparam int unsigned MAX_WIDTH_DEF  = 1024;
	localparam int unsigned MAX_HEIGHT_DEF = 1024;

	localparam int unsigned CH_W    = 8;
	localparam int unsigned SUM_W   = 11;  // five channels of 255
	localparam int unsigned COORD_W = 10;
	localparam int unsigned CFG_W   = 11;
	localparam int unsigned APB_W   = 32;
	localparam int unsigned ADDR_W  = 3;
	localparam int unsigned NUM_W   = 20;  // 510*C + A
	localparam int unsigned DEN_W   = 12;  // 2*A
	localparam int unsigned LANES   = 3;

	localparam int unsigned JOB_DEPTH = 4;
	localparam int unsigned OUT_DEPTH = 4;

	localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(64);

	localparam logic [CH_W-1:0] FILL_R    = 8'd77;
	localparam logic [CH_W-1:0] FILL_G    = 8'd77;
	localparam logic [CH_W-1:0] FILL_B    = 8'd255;
	localparam logic [CH_W-1:0] ALPHA_ONE = 8'd255;
	localparam logic [CH_W-1:0] CH_MAX    = 8'd255;

	typedef enum logic {
		REG_FRAME_WIDTH,
		REG_FRAME_HEIGHT
	} reg_idx_t;

	typedef struct packed {
		logic [CH_W-1:0] a;
		logic [CH_W-1:0] b;
		logic [CH_W-1:0] g;
		logic [CH_W-1:0] r;
	} rgba_t;

	typedef struct packed {
		logic [SUM_W-1:0]   sum_r;
		logic [SUM_W-1:0]   sum_g;
		logic [SUM_W-1:0]   sum_b;
		logic [SUM_W-1:0]   sum_a;
		logic [COORD_W-1:0] col;
		logic [COORD_W-1:0] row;
		logic               fend;
		logic               last;
	} job_t;

	typedef struct packed {
		logic [CH_W-1:0]    r;
		logic [CH_W-1:0]    g;
		logic [CH_W-1:0]    b;
		logic [COORD_W-1:0] col;
		logic [COORD_W-1:0] row;
		logic               filled;
		logic               last;
		logic               fend;
	} pix_out_t;

	function automatic logic [SUM_W-1:0] sum5(input logic [CH_W-1:0] a, input logic [CH_W-1:0] b,
			input logic [CH_W-1:0] c, input logic [CH_W-1:0] d, input logic [CH_W-1:0] e);
		sum5 = SUM_W'(a) + SUM_W'(b) + SUM_W'(c) + SUM_W'(d) + SUM_W'(e);
	endfunction

endpackage

>>> design/ancb_fifo.sv
// ----------------------------------------------------------------------------
// ancb_fifo
// Small register FIFO with push/full and pop/empty sides.
// ----------------------------------------------------------------------------
module ancb_fifo #(
	parameter type         T     = logic,
	parameter int unsigned DEPTH = 4
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  T     din,
	output logic full,
	input  logic pop,
	output T     dout,
	output logic empty
);

	localparam int unsigned PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNTW = $clog2(DEPTH + 1);

	T                mem_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CNTW-1:0] count_q;
	logic            do_push;
	logic            do_pop;

	assign full    = (count_q == CNTW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNTW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNTW'(1);
			end
		end
	end

endmodule

>>> design/ancb_front.sv
// ----------------------------------------------------------------------------
// ancb_front
// Accept pixels, keep the two line stores, gather cross neighborhoods and
// issue channel sums as divide jobs.
// ----------------------------------------------------------------------------
module ancb_front #(
	parameter int unsigned MAX_WIDTH  = ancb_pkg::MAX_WIDTH_DEF,
	parameter int unsigned MAX_HEIGHT = ancb_pkg::MAX_HEIGHT_DEF,
	localparam int unsigned CW  = $clog2(MAX_WIDTH + 1),
	localparam int unsigned RHW = $clog2(MAX_HEIGHT + 1)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 restart,
	input  logic [CW-1:0]        w_eff,
	input  logic [RHW-1:0]       h_eff,
	input  logic                 push,
	input  ancb_pkg::rgba_t      pix_in,
	output logic                 full,
	output logic                 job_push,
	output ancb_pkg::job_t       job,
	input  logic                 job_full
);

	localparam int unsigned AW = $clog2(MAX_WIDTH);

	typedef enum logic {
		S_IDLE,
		S_WORK
	} state_t;

	typedef enum logic [1:0] {
		SEL_UPPER,
		SEL_LEFT,
		SEL_CORNER
	} sel_t;

	localparam int unsigned NSEL = 3;

	state_t          state_q;
	logic [CW-1:0]   col_q;
	logic [RHW-1:0]  row_q;
	ancb_pkg::rgba_t left_q;
	ancb_pkg::rgba_t prev1_q;
	ancb_pkg::rgba_t prev2_q;
	ancb_pkg::rgba_t pix_q;
	logic [NSEL-1:0] jobs_q;

	ancb_pkg::rgba_t center_mem [MAX_WIDTH];
	ancb_pkg::rgba_t upper_mem  [MAX_WIDTH];
	ancb_pkg::rgba_t oc_rd_q;
	ancb_pkg::rgba_t right_rd_q;
	ancb_pkg::rgba_t up_rd_q;

	logic [CW-1:0]   col_nx;
	logic [RHW-1:0]  row_nx;
	logic            accept;
	logic            last_row;
	logic [NSEL-1:0] new_jobs;
	logic [NSEL-1:0] rem_jobs;
	logic            has_left;
	logic            has_left2;
	logic            has_right;
	logic            has_up;
	logic            up_first;
	logic            done;
	ancb_pkg::rgba_t nb_s, nb_l, nb_r, nb_u, nb_d;

	// hold off the input while a register write restarts the frame
	assign full     = (state_q != S_IDLE) || restart;
	assign accept   = push && !full;
	assign col_nx   = col_q + CW'(1);
	assign row_nx   = row_q + RHW'(1);
	assign last_row = (row_q == h_eff - RHW'(1));

	assign new_jobs[SEL_UPPER]  = (row_q != '0);
	assign new_jobs[SEL_LEFT]   = last_row && (col_q != '0);
	assign new_jobs[SEL_CORNER] = last_row && (col_nx == w_eff);

	assign has_left  = (col_q != '0);
	assign has_left2 = (col_q >= CW'(2));
	assign has_right = (col_nx < w_eff);
	assign has_up    = (row_q != '0);
	assign up_first  = (row_q == RHW'(1));

	// pick the oldest pending result of this pixel and its five taps
	always_comb begin
		nb_s     = pix_q;
		nb_l     = pix_q;
		nb_r     = pix_q;
		nb_u     = pix_q;
		nb_d     = pix_q;
		rem_jobs = jobs_q;
		job      = '0;
		if (jobs_q[SEL_UPPER]) begin
			nb_s     = oc_rd_q;
			nb_l     = has_left ? left_q : oc_rd_q;
			nb_r     = has_right ? right_rd_q : oc_rd_q;
			nb_u     = up_first ? oc_rd_q : up_rd_q;
			nb_d     = pix_q;
			job.col  = ancb_pkg::COORD_W'(col_q);
			job.row  = ancb_pkg::COORD_W'(row_q - RHW'(1));
			rem_jobs[SEL_UPPER] = 1'b0;
		end else if (jobs_q[SEL_LEFT]) begin
			nb_s     = prev1_q;
			nb_l     = has_left2 ? prev2_q : prev1_q;
			nb_r     = pix_q;
			nb_u     = has_up ? left_q : prev1_q;
			nb_d     = prev1_q;
			job.col  = ancb_pkg::COORD_W'(col_q - CW'(1));
			job.row  = ancb_pkg::COORD_W'(row_q);
			rem_jobs[SEL_LEFT] = 1'b0;
		end else if (jobs_q[SEL_CORNER]) begin
			nb_l     = has_left ? prev1_q : pix_q;
			nb_u     = has_up ? oc_rd_q : pix_q;
			job.col  = ancb_pkg::COORD_W'(col_q);
			job.row  = ancb_pkg::COORD_W'(row_q);
			job.fend = 1'b1;
			rem_jobs[SEL_CORNER] = 1'b0;
		end
		job.sum_r = ancb_pkg::sum5(nb_s.r, nb_l.r, nb_r.r, nb_u.r, nb_d.r);
		job.sum_g = ancb_pkg::sum5(nb_s.g, nb_l.g, nb_r.g, nb_u.g, nb_d.g);
		job.sum_b = ancb_pkg::sum5(nb_s.b, nb_l.b, nb_r.b, nb_u.b, nb_d.b);
		job.sum_a = ancb_pkg::sum5(nb_s.a, nb_l.a, nb_r.a, nb_u.a, nb_d.a);
		job.last  = (rem_jobs == '0);
	end

	assign job_push = (state_q == S_WORK) && (jobs_q != '0) && !job_full;
	assign done     = (state_q == S_WORK) && ((jobs_q == '0) || (job_push && job.last));

	// line stores: read at accept, write back when the pixel retires
	always_ff @(posedge clk) begin
		if (accept) begin
			oc_rd_q    <= center_mem[col_q[AW-1:0]];
			right_rd_q <= center_mem[col_nx[AW-1:0]];
			up_rd_q    <= upper_mem[col_q[AW-1:0]];
		end
		if (done) begin
			upper_mem[col_q[AW-1:0]]  <= oc_rd_q;
			center_mem[col_q[AW-1:0]] <= pix_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			col_q   <= '0;
			row_q   <= '0;
			left_q  <= '0;
			jobs_q  <= '0;
			pix_q   <= '0;
			prev1_q <= '0;
			prev2_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (restart) begin
						col_q  <= '0;
						row_q  <= '0;
						left_q <= '0;
					end else if (accept) begin
						pix_q   <= pix_in;
						jobs_q  <= new_jobs;
						state_q <= S_WORK;
					end
				end
				S_WORK: begin
					if (job_push) begin
						jobs_q <= rem_jobs;
					end
					if (done) begin
						prev1_q <= pix_q;
						prev2_q <= prev1_q;
						if (col_nx >= w_eff) begin
							col_q  <= '0;
							left_q <= '0;
							row_q  <= (row_nx >= h_eff) ? '0 : row_nx;
						end else begin
							col_q  <= col_nx;
							left_q <= oc_rd_q;
						end
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

>>> design/ancb_back.sv
// ----------------------------------------------------------------------------
// ancb_back
// Pipelined restoring divider: three color lanes, one quotient bit per stage.
// ----------------------------------------------------------------------------
module ancb_back (
	input  logic                clk,
	input  logic                arst_n,
	input  ancb_pkg::job_t      job,
	input  logic                job_empty,
	output logic                job_pop,
	output logic                res_push,
	output ancb_pkg::pix_out_t  res,
	input  logic                res_full
);

	localparam int unsigned STEPS = ancb_pkg::CH_W;
	localparam int unsigned LANES = ancb_pkg::LANES;
	localparam int unsigned NUM_W = ancb_pkg::NUM_W;

	typedef struct packed {
		logic                                 vld;
		logic [LANES-1:0][NUM_W-1:0]          rem;
		logic [ancb_pkg::DEN_W-1:0]           den;
		logic [LANES-1:0][STEPS-1:0]          quo;
		logic [LANES-1:0]                     sat;
		logic                                 filled;
		logic [ancb_pkg::COORD_W-1:0]         col;
		logic [ancb_pkg::COORD_W-1:0]         row;
		logic                                 fend;
		logic                                 last;
	} div_t;

	div_t                                    div_s [STEPS+1];
	logic                                    advance;
	logic [LANES-1:0][ancb_pkg::SUM_W-1:0]   csum;
	logic [LANES-1:0][ancb_pkg::CH_W-1:0]    chan;

	// 510*C + A as shift and add
	function automatic logic [NUM_W-1:0] numer(input logic [ancb_pkg::SUM_W-1:0] c,
			input logic [ancb_pkg::SUM_W-1:0] a);
		numer = (NUM_W'(c) << 9) - (NUM_W'(c) << 1) + NUM_W'(a);
	endfunction

	assign csum    = {job.sum_b, job.sum_g, job.sum_r};
	assign advance = !(div_s[STEPS].vld && res_full);
	assign job_pop = advance && !job_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_s[0] <= '0;
		end else if (advance) begin
			div_s[0].vld    <= !job_empty;
			for (int c = 0; c < LANES; c++) begin
				div_s[0].rem[c] <= numer(csum[c], job.sum_a);
			end
			div_s[0].den    <= {job.sum_a, 1'b0};
			div_s[0].quo    <= '0;
			div_s[0].sat    <= '0;
			div_s[0].filled <= (job.sum_a == '0);
			div_s[0].col    <= job.col;
			div_s[0].row    <= job.row;
			div_s[0].fend   <= job.fend;
			div_s[0].last   <= job.last;
		end
	end

	for (genvar k = 0; k < STEPS; k++) begin : g_step
		localparam int unsigned B = STEPS - 1 - k;
		div_t nxt;

		always_comb begin
			nxt = div_s[k];
			for (int c = 0; c < LANES; c++) begin
				if (div_s[k].rem[c] >= (NUM_W'(div_s[k].den) << B)) begin
					nxt.rem[c]    = div_s[k].rem[c] - (NUM_W'(div_s[k].den) << B);
					nxt.quo[c][B] = 1'b1;
				end
				// quotient does not fit in eight bits: clip to full scale
				if (k == 0) begin
					nxt.sat[c] = (div_s[k].rem[c] >= (NUM_W'(div_s[k].den) << STEPS));
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				div_s[k+1] <= '0;
			end else if (advance) begin
				div_s[k+1] <= nxt;
			end
		end
	end

	always_comb begin
		for (int c = 0; c < LANES; c++) begin
			chan[c] = div_s[STEPS].sat[c] ? ancb_pkg::CH_MAX : div_s[STEPS].quo[c];
		end
		res.r      = div_s[STEPS].filled ? ancb_pkg::FILL_R : chan[0];
		res.g      = div_s[STEPS].filled ? ancb_pkg::FILL_G : chan[1];
		res.b      = div_s[STEPS].filled ? ancb_pkg::FILL_B : chan[2];
		res.col    = div_s[STEPS].col;
		res.row    = div_s[STEPS].row;
		res.filled = div_s[STEPS].filled;
		res.last   = div_s[STEPS].last;
		res.fend   = div_s[STEPS].fend;
	end

	assign res_push = div_s[STEPS].vld && !res_full;

endmodule

>>> design/alpha_normalized_cross_blur.sv
// ----------------------------------------------------------------------------
// alpha_normalized_cross_blur
// Alpha-normalized 5-point cross blur over an RGBA raster stream.
// ----------------------------------------------------------------------------
// Push the pixels of a frame in raster order; each result is the per-channel
// sum of a pixel and its four cross neighbors (edges replicate the pixel),
// colors divided by the alpha sum, rounded, clipped at 255, alpha 255, or the
// fill color (77,77,255) with filled set when the alpha sum is zero. Results
// trail the input by one row, except the last row, which retires as it
// arrives: the final pixel of a frame gives a burst of up to three results,
// the last one marked frame_end, and run_last marks the last result of each
// pixel. The front accepts a pixel and reads the line stores while idle, then
// retires it and issues its results one per cycle while the job queue has
// room, and takes no new pixel before the last one is issued; each line store
// has a single write port. The back is a nine stage divider that takes one
// result per cycle unless a finished result waits on a full result queue, so
// each side stalls on its own across four-entry job and result queues. Writing
// frame_width or frame_height restarts the frame at (0,0); write only while
// the block is idle. The line stores need no clearing after reset.
// ----------------------------------------------------------------------------
module alpha_normalized_cross_blur #(
	parameter int unsigned MAX_WIDTH  = ancb_pkg::MAX_WIDTH_DEF,
	parameter int unsigned MAX_HEIGHT = ancb_pkg::MAX_HEIGHT_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// configuration port
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [ancb_pkg::ADDR_W-1:0]    paddr,
	input  logic [ancb_pkg::APB_W-1:0]     pwdata,
	output logic [ancb_pkg::APB_W-1:0]     prdata,
	output logic                           pready,
	// pixel input
	input  logic                           push,
	output logic                           full,
	input  logic [ancb_pkg::CH_W-1:0]      red_in,
	input  logic [ancb_pkg::CH_W-1:0]      green_in,
	input  logic [ancb_pkg::CH_W-1:0]      blue_in,
	input  logic [ancb_pkg::CH_W-1:0]      alpha_in,
	// results
	output logic                           empty,
	input  logic                           pop,
	output logic [ancb_pkg::CH_W-1:0]      red_out,
	output logic [ancb_pkg::CH_W-1:0]      green_out,
	output logic [ancb_pkg::CH_W-1:0]      blue_out,
	output logic [ancb_pkg::CH_W-1:0]      alpha_out,
	output logic [ancb_pkg::COORD_W-1:0]   col_out,
	output logic [ancb_pkg::COORD_W-1:0]   row_out,
	output logic                           filled,
	output logic                           run_last,
	output logic                           frame_end
);

	localparam int unsigned CW  = $clog2(MAX_WIDTH + 1);
	localparam int unsigned RHW = $clog2(MAX_HEIGHT + 1);

	logic [ancb_pkg::CFG_W-1:0] width_q;
	logic [ancb_pkg::CFG_W-1:0] height_q;
	logic [CW-1:0]              w_eff;
	logic [RHW-1:0]             h_eff;
	logic                       cfg_wr;
	ancb_pkg::reg_idx_t         reg_sel;

	ancb_pkg::rgba_t            pix_in;
	ancb_pkg::job_t             job_in;
	ancb_pkg::job_t             job_out;
	logic                       job_push;
	logic                       job_full;
	logic                       job_pop;
	logic                       job_empty;
	ancb_pkg::pix_out_t         res_in;
	ancb_pkg::pix_out_t         res_out;
	logic                       res_push;
	logic                       res_full;

	// register file: one transfer per access phase, no wait states
	assign pready  = 1'b1;
	assign reg_sel = ancb_pkg::reg_idx_t'(paddr[2]);
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_comb begin
		case (reg_sel)
			ancb_pkg::REG_FRAME_WIDTH:  prdata = ancb_pkg::APB_W'(width_q);
			ancb_pkg::REG_FRAME_HEIGHT: prdata = ancb_pkg::APB_W'(height_q);
			default:                    prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= ancb_pkg::CFG_RESET;
			height_q <= ancb_pkg::CFG_RESET;
		end else if (cfg_wr) begin
			case (reg_sel)
				ancb_pkg::REG_FRAME_WIDTH:  width_q  <= pwdata[ancb_pkg::CFG_W-1:0];
				ancb_pkg::REG_FRAME_HEIGHT: height_q <= pwdata[ancb_pkg::CFG_W-1:0];
				default: ;
			endcase
		end
	end

	// clamp the frame size to 1..MAX
	always_comb begin
		if (width_q == '0) begin
			w_eff = CW'(1);
		end else if (32'(width_q) > 32'(MAX_WIDTH)) begin
			w_eff = CW'(MAX_WIDTH);
		end else begin
			w_eff = CW'(width_q);
		end
		if (height_q == '0) begin
			h_eff = RHW'(1);
		end else if (32'(height_q) > 32'(MAX_HEIGHT)) begin
			h_eff = RHW'(MAX_HEIGHT);
		end else begin
			h_eff = RHW'(height_q);
		end
	end

	assign pix_in = '{a: alpha_in, b: blue_in, g: green_in, r: red_in};

	// front: line stores and neighborhood sums
	ancb_front #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.restart  (cfg_wr),
		.w_eff    (w_eff),
		.h_eff    (h_eff),
		.push     (push),
		.pix_in   (pix_in),
		.full     (full),
		.job_push (job_push),
		.job      (job_in),
		.job_full (job_full)
	);

	// decouple the front from the divider
	ancb_fifo #(
		.T     (ancb_pkg::job_t),
		.DEPTH (ancb_pkg::JOB_DEPTH)
	) u_job_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (job_push),
		.din    (job_in),
		.full   (job_full),
		.pop    (job_pop),
		.dout   (job_out),
		.empty  (job_empty)
	);

	// back: normalize colors by the alpha sum
	ancb_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job       (job_out),
		.job_empty (job_empty),
		.job_pop   (job_pop),
		.res_push  (res_push),
		.res       (res_in),
		.res_full  (res_full)
	);

	// hold finished results until the consumer pops them
	ancb_fifo #(
		.T     (ancb_pkg::pix_out_t),
		.DEPTH (ancb_pkg::OUT_DEPTH)
	) u_out_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.din    (res_in),
		.full   (res_full),
		.pop    (pop),
		.dout   (res_out),
		.empty  (empty)
	);

	assign red_out   = res_out.r;
	assign green_out = res_out.g;
	assign blue_out  = res_out.b;
	assign alpha_out = ancb_pkg::ALPHA_ONE;
	assign col_out   = res_out.col;
	assign row_out   = res_out.row;
	assign filled    = res_out.filled;
	assign run_last  = res_out.last;
	assign frame_end = res_out.fend;

endmodule

>>> design/ancb_checker.sv
// ----------------------------------------------------------------------------
// ancb_checker
// Port-level checks on the cross blur, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ancb_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           push,
	input logic                           full,
	input logic                           empty,
	input logic                           pop,
	input logic [ancb_pkg::CH_W-1:0]      red_out,
	input logic [ancb_pkg::CH_W-1:0]      green_out,
	input logic [ancb_pkg::CH_W-1:0]      blue_out,
	input logic [ancb_pkg::COORD_W-1:0]   col_out,
	input logic [ancb_pkg::COORD_W-1:0]   row_out,
	input logic                           filled,
	input logic                           run_last,
	input logic                           frame_end
);

	// an accepted pixel keeps the input busy for at least its retire cycle
	`ASSERT_NEXT(a_busy_after_transfer, push && !full, full, "input not busy after transfer")

	// the fill color goes out exactly as specified
	`ASSERT_HOLDS(a_fill_color, !empty && filled |-> red_out == ancb_pkg::FILL_R && green_out == ancb_pkg::FILL_G && blue_out == ancb_pkg::FILL_B, "wrong fill color")

	// the final pixel of a frame is always the last result of its input
	`ASSERT_HOLDS(a_frame_end_last, !empty && frame_end |-> run_last, "frame end without run end")

	// a waiting result holds until it is popped
	`ASSERT_NEXT(a_result_hold, !empty && !pop, !empty && $stable(red_out) && $stable(col_out) && $stable(row_out), "waiting result changed")

endmodule

bind alpha_normalized_cross_blur ancb_checker u_ancb_checker (.*);

>>> dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the alpha-normalized cross blur: streams frames
// through the pixel input, predicts every filtered pixel and compares it.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int GAP_MAX     = 14;
	localparam int HOLD_CYCLES = 400;   // long receiver hold-off to fill the queues
	localparam int QUIET       = 40;    // front plus divider depth, with margin
	localparam int WDOG_LIMIT  = 3000;  // cycles without any transfer
	localparam int RAND_ITEMS  = 210;
	localparam int MAX_REPORT  = 10;

	typedef struct packed {
		logic [7:0] r, g, b, a;
		logic [9:0] col, row;
		logic       filled, last, fend;
	} blur_res_t;

	// directed stimulus row; cfg forces a register write (frame restart) first
	typedef struct {
		bit         cfg;
		int         w, h;
		logic [7:0] r, g, b, a;
		bit         chk;
		logic [7:0] er, eg, eb;
		bit         ef;
	} stim_row_t;

	logic clk, arst_n;
	logic psel, penable, pwrite;
	logic [ancb_pkg::ADDR_W-1:0] paddr;
	logic [ancb_pkg::APB_W-1:0]  pwdata, prdata;
	logic pready;
	logic push, full, empty, pop;
	logic [7:0] red_in, green_in, blue_in, alpha_in;
	logic [7:0] red_out, green_out, blue_out, alpha_out;
	logic [9:0] col_out, row_out;
	logic filled, run_last, frame_end;

	alpha_normalized_cross_blur dut (.*);

	// predictor state
	ancb_pkg::rgba_t line_cur [ancb_pkg::MAX_WIDTH_DEF];
	ancb_pkg::rgba_t line_up  [ancb_pkg::MAX_WIDTH_DEF];
	ancb_pkg::rgba_t left_px;
	int         col_cnt, row_cnt;
	logic [10:0] width_reg, height_reg;

	blur_res_t  pending_q[$];
	int         errors, wdog;
	bit         no_idle, hold_req;

	stim_row_t dir_tab[] = '{
		// 1x1 frame: every neighbor is the pixel itself, so out = round(255*c/a)
		'{1, 1, 1, 8'd0,   8'd0,   8'd0,   8'd0,   1, 8'd77,  8'd77, 8'd255, 1},
		'{0, 1, 1, 8'd255, 8'd255, 8'd255, 8'd255, 1, 8'd255, 8'd255, 8'd255, 0},
		'{0, 1, 1, 8'd255, 8'd0,   8'd128, 8'd255, 1, 8'd255, 8'd0,  8'd128, 0},
		'{0, 1, 1, 8'd200, 8'd200, 8'd200, 8'd100, 1, 8'd255, 8'd255, 8'd255, 0},
		'{0, 1, 1, 8'd1,   8'd0,   8'd0,   8'd255, 1, 8'd1,   8'd0,  8'd0,   0},
		'{0, 1, 1, 8'd255, 8'd255, 8'd0,   8'd1,   1, 8'd255, 8'd255, 8'd0,  0},
		// 3x2: partial frame, then restart by a register write
		'{1, 3, 2, 8'd10,  8'd20,  8'd30,  8'd255, 0, 0, 0, 0, 0},
		'{0, 3, 2, 8'd0,   8'd0,   8'd0,   8'd0,   0, 0, 0, 0, 0},
		'{0, 3, 2, 8'd90,  8'd80,  8'd70,  8'd60,  0, 0, 0, 0, 0},
		'{0, 3, 2, 8'd255, 8'd1,   8'd2,   8'd3,   0, 0, 0, 0, 0},
		'{1, 3, 2, 8'd5,   8'd6,   8'd7,   8'd8,   0, 0, 0, 0, 0},
		'{0, 3, 2, 8'd0,   8'd0,   8'd0,   8'd0,   0, 0, 0, 0, 0},
		'{0, 3, 2, 8'd128, 8'd64,  8'd32,  8'd255, 0, 0, 0, 0, 0},
		'{0, 3, 2, 8'd17,  8'd34,  8'd51,  8'd1,   0, 0, 0, 0, 0},
		'{0, 3, 2, 8'd0,   8'd0,   8'd0,   8'd0,   0, 0, 0, 0, 0},
		'{0, 3, 2, 8'd255, 8'd255, 8'd255, 8'd0,   0, 0, 0, 0, 0},
		// 2x1: all-zero coverage next to full coverage
		'{1, 2, 1, 8'd0,   8'd0,   8'd0,   8'd0,   0, 0, 0, 0, 0},
		'{0, 2, 1, 8'd255, 8'd0,   8'd255, 8'd255, 0, 0, 0, 0, 0}
	};

	// ------------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------------
	function automatic blur_res_t cross_blur(ancb_pkg::rgba_t s, ancb_pkg::rgba_t l,
			ancb_pkg::rgba_t r, ancb_pkg::rgba_t u, ancb_pkg::rgba_t d,
			int col, int row, bit fe);
		blur_res_t res;
		int sr, sg, sb, sa;
		sr = int'(s.r) + int'(l.r) + int'(r.r) + int'(u.r) + int'(d.r);
		sg = int'(s.g) + int'(l.g) + int'(r.g) + int'(u.g) + int'(d.g);
		sb = int'(s.b) + int'(l.b) + int'(r.b) + int'(u.b) + int'(d.b);
		sa = int'(s.a) + int'(l.a) + int'(r.a) + int'(u.a) + int'(d.a);
		if (sa > 0) begin
			// rounded division by the coverage sum, clipped at full scale
			res.r = 8'(((510 * sr + sa) / (2 * sa) > 255) ? 255 : (510 * sr + sa) / (2 * sa));
			res.g = 8'(((510 * sg + sa) / (2 * sa) > 255) ? 255 : (510 * sg + sa) / (2 * sa));
			res.b = 8'(((510 * sb + sa) / (2 * sa) > 255) ? 255 : (510 * sb + sa) / (2 * sa));
			res.filled = 1'b0;
		end else begin
			res.r = ancb_pkg::FILL_R;
			res.g = ancb_pkg::FILL_G;
			res.b = ancb_pkg::FILL_B;
			res.filled = 1'b1;
		end
		res.a    = ancb_pkg::ALPHA_ONE;
		res.col  = 10'(col);
		res.row  = 10'(row);
		res.last = 1'b0;
		res.fend = fe;
		return res;
	endfunction

	// advance the predictor by one accepted pixel and queue its results
	task automatic blur_accept(input ancb_pkg::rgba_t p, output blur_res_t last_res,
			output int n);
		int w, h, x, y;
		ancb_pkg::rgba_t oc, s, l, r, u;
		blur_res_t res[3];
		w = (width_reg == 0) ? 1 : (width_reg > ancb_pkg::MAX_WIDTH_DEF) ?
			ancb_pkg::MAX_WIDTH_DEF : width_reg;
		h = (height_reg == 0) ? 1 : (height_reg > ancb_pkg::MAX_HEIGHT_DEF) ?
			ancb_pkg::MAX_HEIGHT_DEF : height_reg;
		x = (col_cnt >= w) ? 0 : col_cnt;
		y = (row_cnt >= h) ? 0 : row_cnt;
		n = 0;
		oc = line_cur[x];
		// the pixel above is complete once its lower neighbor arrives
		if (y >= 1) begin
			l = (x > 0) ? left_px : oc;
			r = (x + 1 < w) ? line_cur[x + 1] : oc;
			u = (y == 1) ? oc : line_up[x];
			res[n++] = cross_blur(oc, l, r, u, p, x, y - 1, 0);
		end
		line_up[x]  = oc;
		line_cur[x] = p;
		left_px     = oc;
		// last row retires as it arrives
		if (y == h - 1) begin
			if (x >= 1) begin
				s = line_cur[x - 1];
				l = (x >= 2) ? line_cur[x - 2] : s;
				u = (y > 0) ? line_up[x - 1] : s;
				res[n++] = cross_blur(s, l, p, u, s, x - 1, y, 0);
			end
			if (x == w - 1) begin
				l = (x > 0) ? line_cur[x - 1] : p;
				u = (y > 0) ? line_up[x] : p;
				res[n++] = cross_blur(p, l, p, u, p, x, y, 1);
			end
		end
		if (n > 0)
			res[n - 1].last = 1'b1;
		for (int i = 0; i < n; i++)
			pending_q.push_back(res[i]);
		if (n > 0)
			last_res = res[n - 1];
		x++;
		if (x >= w) begin
			x = 0;
			y++;
			if (y >= h)
				y = 0;
			left_px = '0;
		end
		col_cnt = x;
		row_cnt = y;
	endtask

	// ------------------------------------------------------------------------
	// Clock, reset, checker and watchdog
	// ------------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// compare each popped result against the oldest expectation
	always @(posedge clk) begin
		blur_res_t got, want;
		if (arst_n) begin
			wdog <= ((push && !full) || (pop && !empty)) ? 0 : wdog + 1;
			if (wdog >= WDOG_LIMIT) begin
				$display("watchdog: no transfer for %0d cycles", WDOG_LIMIT);
				$display("testbench NOT OK");
				$finish;
			end
			if (pop && !empty) begin
				got = '{red_out, green_out, blue_out, alpha_out, col_out, row_out,
					filled, run_last, frame_end};
				if (pending_q.size() == 0) begin
					errors++;
					if (errors <= MAX_REPORT)
						$display("unexpected result %p", got);
				end else begin
					want = pending_q.pop_front();
					if (got !== want) begin
						errors++;
						if (errors <= MAX_REPORT)
							$display("mismatch at (%0d,%0d): expected %p, got %p",
								want.col, want.row, want, got);
					end
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Result side: random pop gaps, plus one long hold-off on request
	// ------------------------------------------------------------------------
	initial begin
		int gap;
		pop = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			gap = no_idle ? 0 : $urandom_range(0, GAP_MAX);
			if (hold_req) begin
				gap = HOLD_CYCLES;
				hold_req = 1'b0;
			end
			if (gap > 0) begin
				pop <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			pop <= 1'b1;
			do @(posedge clk); while (empty);
		end
	end

	// ------------------------------------------------------------------------
	// Pixel side
	// ------------------------------------------------------------------------
	// one register transfer: setup cycle, then access cycle
	task automatic reg_write(input ancb_pkg::reg_idx_t idx, input logic [10:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ancb_pkg::ADDR_W'(int'(idx) * 4);
		pwdata  <= ancb_pkg::APB_W'(val);
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (idx == ancb_pkg::REG_FRAME_WIDTH)
			width_reg = val;
		else
			height_reg = val;
		col_cnt = 0;
		row_cnt = 0;
		left_px = '0;
	endtask

	// drain outstanding results, let the pipeline settle, then set the frame size
	task automatic set_frame(input logic [10:0] w, input logic [10:0] h);
		push <= 1'b0;
		wait (pending_q.size() == 0);
		repeat (QUIET) @(negedge clk);
		reg_write(ancb_pkg::REG_FRAME_WIDTH, w);
		reg_write(ancb_pkg::REG_FRAME_HEIGHT, h);
	endtask

	// offer one pixel, hold it until transferred; returns at a falling edge
	task automatic send_pixel(input ancb_pkg::rgba_t p, output blur_res_t last_res,
			output int n);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, GAP_MAX);
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		red_in   <= p.r;
		green_in <= p.g;
		blue_in  <= p.b;
		alpha_in <= p.a;
		push     <= 1'b1;
		do @(posedge clk); while (full);
		blur_accept(p, last_res, n);
		@(negedge clk);
	endtask

	// random pixel; sparse mode leaves most coverage at zero to hit the fill color
	function automatic ancb_pkg::rgba_t rand_pixel(bit sparse);
		ancb_pkg::rgba_t p;
		p = ancb_pkg::rgba_t'($urandom);
		if (sparse && $urandom_range(0, 3) != 0)
			p.a = 8'd0;
		return p;
	endfunction

	task automatic send_frame(input int w, input int h, input int count, input bit sparse);
		blur_res_t lr;
		int n;
		set_frame(11'(w), 11'(h));
		repeat (count) send_pixel(rand_pixel(sparse), lr, n);
	endtask

	initial begin
		blur_res_t lr;
		int n, sent, w, h, count;
		arst_n = 1'b0;
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
		push = 1'b0; red_in = '0; green_in = '0; blue_in = '0; alpha_in = '0;
		errors = 0; wdog = 0; no_idle = 1'b0; hold_req = 1'b0;
		width_reg = ancb_pkg::CFG_RESET; height_reg = ancb_pkg::CFG_RESET;
		col_cnt = 0; row_cnt = 0; left_px = '0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed part: walk the table
		foreach (dir_tab[i]) begin
			if (dir_tab[i].cfg)
				set_frame(11'(dir_tab[i].w), 11'(dir_tab[i].h));
			send_pixel(ancb_pkg::rgba_t'({dir_tab[i].a, dir_tab[i].b, dir_tab[i].g,
				dir_tab[i].r}), lr, n);
			if (dir_tab[i].chk && (n == 0 || lr.r !== dir_tab[i].er ||
					lr.g !== dir_tab[i].eg || lr.b !== dir_tab[i].eb ||
					lr.filled !== dir_tab[i].ef)) begin
				errors++;
				if (errors <= MAX_REPORT)
					$display("table row %0d: predicted %p", i, lr);
			end
		end

		// size extremes, including out-of-range values that clamp
		send_frame(0, 0, 3, 0);
		send_frame(1024, 1, 30, 0);
		send_frame(2047, 1, 40, 1);
		send_frame(1, 2047, 20, 0);

		// fill the queues behind a long receiver hold-off
		hold_req = 1'b1;
		send_frame(4, 5, 40, 0);

		// random frames, some cut short by a restart
		sent = 0;
		while (sent < RAND_ITEMS) begin
			no_idle = ($urandom_range(0, 3) == 0);
			w = ($urandom_range(0, 4) == 0) ? $urandom_range(11, 40) : $urandom_range(1, 10);
			h = $urandom_range(1, 5);
			count = ($urandom_range(0, 4) == 0) ? $urandom_range(1, w * h)
				: w * h * $urandom_range(1, 2);
			if (count > RAND_ITEMS - sent)
				count = RAND_ITEMS - sent;
			send_frame(w, h, count, $urandom_range(0, 3) == 0);
			sent += count;
		end
		no_idle = 1'b0;
		push <= 1'b0;

		// drain and settle
		wait (pending_q.size() == 0);
		repeat (QUIET) @(negedge clk);
		if (errors == 0 && pending_q.size() == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end
endmodule

>>> filelist.f
+incdir+design
design/ancb_pkg.sv
design/ancb_fifo.sv
design/ancb_front.sv
design/ancb_back.sv
design/alpha_normalized_cross_blur.sv
design/ancb_checker.sv
dv/testbench.sv
